// File: design/rlhp_pkg.sv
// ----------------------------------------------------------------------------
// rlhp_pkg
// Shared types, constants and action/status codes of the run-length packer.
// ----------------------------------------------------------------------------
package rlhp_pkg;

    localparam int WORD_BITS_DEF     = 32;
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int RUN_BITS_DEF      = 16;

    // field widths fixed by the item format
    localparam int SYM_W   = 8;
    localparam int SLOT_W  = 8;
    localparam int ERUN_W  = 16;
    localparam int CODE_W  = 32;
    localparam int CLEN_W  = 6;
    localparam int OWORD_W = 32;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_DATA = 2'd1;
    localparam logic [1:0] ACT_EOS  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_CODE  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] entry_slot;
        logic [SYM_W-1:0]  entry_symbol;
        logic [ERUN_W-1:0] entry_run_length;
        logic [CODE_W-1:0] entry_code;
        logic [CLEN_W-1:0] entry_code_length;
        logic [SYM_W-1:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [OWORD_W-1:0] packed_word;
        logic               word_valid;
        logic               last;
        logic [1:0]         status;
    } out_item_t;

    // lookup request travelling down the cell row
    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  symbol;
        logic [ERUN_W-1:0] run_len;
        logic              hit;
        logic [CODE_W-1:0] code;
        logic [CLEN_W-1:0] code_len;
    } probe_t;

endpackage

// File: design/rlhp_if.sv
// ----------------------------------------------------------------------------
// rlhp_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface rlhp_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/run_length_huffman_bit_packer_core.sv
// ----------------------------------------------------------------------------
// run_length_huffman_bit_packer_core
// Run-length grouping, codeword lookup and MSB-first word packing.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request items (load table entry, data byte, end of stream).
//   out_ch : result requests (packed word, valid, last, status).
// Loads write one cell of the table row. A data byte that continues a run
// only extends the run. A byte that closes a run, or end of stream with a
// run open, sends a probe down the row of TABLE_ENTRIES cells, one cell a
// cycle. Results go to a two-entry output queue; input is held off while a
// probe travels and until the queue has drained, so a stalled receiver
// stalls the input. Reset clears the valid bits of all cells, the run and
// the pack buffer; no clearing pass is needed. Errors (no codeword, run
// overflow) send one result with last set and halt data until end of stream.
// ----------------------------------------------------------------------------
module run_length_huffman_bit_packer_core
    import rlhp_pkg::*;
#(
    parameter int WORD_BITS     = WORD_BITS_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int RUN_BITS      = RUN_BITS_DEF
)
(
    input logic clk,
    input logic rst_n,
    rlhp_if.sink   in_ch,
    rlhp_if.source out_ch
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SYM_W-1:0]    sym_reg;
    logic [RUN_BITS-1:0] cnt_reg;
    logic                open_reg, halt_reg;
    logic                eos_reg;
    logic [SYM_W-1:0]    nsym_reg;
    out_item_t           q_reg [2];
    logic [1:0]          qv_reg;

    probe_t probe [TABLE_ENTRIES+1];
    in_item_t it;
    logic acc;
    logic res0_v, res1_v, failed;
    out_item_t res0, res1;

    assign it = in_ch.data;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign acc = in_ch.valid && in_ch.ready;

    // launch a probe for a closing run
    logic launch;
    always_comb
    begin
        launch = 1'b0;
        if (acc && !halt_reg && open_reg)
        begin
            if (it.action == ACT_EOS)
                launch = 1'b1;
            else if (it.action == ACT_DATA && it.data_byte != sym_reg)
                launch = 1'b1;
        end
        probe[0] = '0;
        probe[0].valid = launch;
        probe[0].symbol = sym_reg;
        probe[0].run_len = ERUN_W'(cnt_reg);
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            rlhp_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .wr(acc && it.action == ACT_LOAD && 32'(it.entry_slot) == g),
                .wdata(it), .probe_in(probe[g]), .probe_out(probe[g+1])
            );
        end
    endgenerate

    logic pk_start;
    assign pk_start = probe[TABLE_ENTRIES].valid ||
                      (acc && it.action == ACT_EOS && !halt_reg && !open_reg);

    // overflow error request
    logic ovf;
    assign ovf = acc && it.action == ACT_DATA && !halt_reg && open_reg &&
                 it.data_byte == sym_reg && cnt_reg == '1;

    rlhp_packer #(.WORD_BITS(WORD_BITS)) u_packer (
        .clk(clk), .rst_n(rst_n), .start(pk_start), .probe(probe[TABLE_ENTRIES]),
        .is_eos(probe[TABLE_ENTRIES].valid ? eos_reg : 1'b1),
        .do_close(probe[TABLE_ENTRIES].valid), .drop(ovf),
        .res0_v(res0_v), .res0(res0), .res1_v(res1_v), .res1(res1), .failed(failed)
    );

    // sequencer, run state and output queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sym_reg <= '0;
            cnt_reg <= '0;
            open_reg <= 1'b0;
            halt_reg <= 1'b0;
            eos_reg <= 1'b0;
            nsym_reg <= '0;
            qv_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (acc && it.action == ACT_DATA && !halt_reg)
            begin
                if (!open_reg)
                begin
                    open_reg <= 1'b1;
                    sym_reg <= it.data_byte;
                    cnt_reg <= RUN_BITS'(1);
                end
                else if (ovf)
                begin
                    open_reg <= 1'b0;
                    cnt_reg <= '0;
                    halt_reg <= 1'b1;
                end
                else if (it.data_byte == sym_reg)
                    cnt_reg <= cnt_reg + RUN_BITS'(1);
                else
                begin
                    eos_reg <= 1'b0;
                    nsym_reg <= it.data_byte;
                end
            end
            if (acc && it.action == ACT_EOS)
            begin
                eos_reg <= 1'b1;
                if (halt_reg || !open_reg)
                begin
                    halt_reg <= 1'b0;
                    open_reg <= 1'b0;
                    sym_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            if (probe[TABLE_ENTRIES].valid)
            begin
                if (eos_reg)
                begin
                    open_reg <= 1'b0;
                    sym_reg <= '0;
                    cnt_reg <= '0;
                end
                else if (failed)
                begin
                    open_reg <= 1'b0;
                    cnt_reg <= '0;
                    halt_reg <= 1'b1;
                end
                else
                begin
                    sym_reg <= nsym_reg;
                    cnt_reg <= RUN_BITS'(1);
                end
            end
            // queue: load new requests or drop the head once taken
            if (ovf)
            begin
                qv_reg <= 2'b01;
            end
            else if (pk_start)
                qv_reg <= {res0_v && res1_v, res0_v || res1_v};
            else if (out_ch.valid && out_ch.ready)
                qv_reg <= {1'b0, qv_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ovf)
        begin
            q_reg[0] <= '{packed_word: '0, word_valid: 1'b0, last: 1'b1,
                          status: ST_OVERFLOW};
        end
        else if (pk_start)
        begin
            q_reg[0] <= res0_v ? res0 : res1;
            q_reg[1] <= res1;
        end
        else if (out_ch.valid && out_ch.ready)
            q_reg[0] <= q_reg[1];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (launch)
                    state_next = S_WAIT;
                else if (ovf || pk_start)
                    state_next = S_OUT;
            end
            S_WAIT:
            begin
                if (probe[TABLE_ENTRIES].valid)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (qv_reg == 2'b00 ||
                    (qv_reg == 2'b01 && out_ch.valid && out_ch.ready))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_ch.valid = qv_reg[0];
    assign out_ch.data = q_reg[0];
endmodule

// File: design/rlhp_cell.sv
// ----------------------------------------------------------------------------
// rlhp_cell
// One table slot: holds an entry and matches the probe passing through.
// ----------------------------------------------------------------------------
module rlhp_cell
    import rlhp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  in_item_t          wdata,
    input  probe_t            probe_in,
    output probe_t            probe_out
);
    logic              written_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [ERUN_W-1:0] run_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CLEN_W-1:0] clen_reg;
    logic              match;

    // hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            written_reg <= 1'b0;
        else if (wr)
            written_reg <= 1'b1;
    end

    // hold the entry payload
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            sym_reg  <= wdata.entry_symbol;
            run_reg  <= wdata.entry_run_length;
            code_reg <= wdata.entry_code;
            clen_reg <= wdata.entry_code_length;
        end
    end

    assign match = written_reg && (clen_reg != '0) && (sym_reg == probe_in.symbol)
                   && (run_reg == probe_in.run_len);

    // advance the probe; the lowest slot sets hit first and keeps it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_out <= '0;
        else
        begin
            probe_out.valid   <= probe_in.valid;
            probe_out.symbol  <= probe_in.symbol;
            probe_out.run_len <= probe_in.run_len;
            if (!probe_in.hit && match)
            begin
                probe_out.hit      <= 1'b1;
                probe_out.code     <= code_reg;
                probe_out.code_len <= clen_reg;
            end
            else
            begin
                probe_out.hit      <= probe_in.hit;
                probe_out.code     <= probe_in.code;
                probe_out.code_len <= probe_in.code_len;
            end
        end
    end
endmodule

// File: design/rlhp_packer.sv
// ----------------------------------------------------------------------------
// rlhp_packer
// Packs found codewords MSB-first into words; builds result requests.
// ----------------------------------------------------------------------------
module rlhp_packer
    import rlhp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,     // probe result ready to consume
    input  probe_t    probe,
    input  logic      is_eos,    // finish with flush
    input  logic      do_close,  // a run was closed into probe
    input  logic      drop,      // discard buffered bits
    output logic      res0_v,
    output out_item_t res0,
    output logic      res1_v,
    output out_item_t res1,
    output logic      failed
);
    localparam int FB_W = $clog2(WORD_BITS + 1);
    localparam int LMAX = (WORD_BITS < 32) ? WORD_BITS : 32;

    logic [WORD_BITS-1:0] buf_reg, buf_next;
    logic [FB_W-1:0]      free_reg, free_next;
    logic [FB_W-1:0]      len, rem;
    logic [63:0]          code64, word64, flush64;
    logic                 full_v;

    always_comb
    begin
        len = (probe.code_len > CLEN_W'(LMAX)) ? FB_W'(LMAX) : FB_W'(probe.code_len);
        code64 = {32'd0, probe.code} & ((64'd1 << len) - 64'd1);
        rem = len - free_reg;
        buf_next = buf_reg;
        free_next = free_reg;
        full_v = 1'b0;
        word64 = '0;
        failed = start && do_close && !probe.hit;
        if (start && do_close && probe.hit)
        begin
            if (len < free_reg)
            begin
                buf_next = WORD_BITS'((64'(buf_reg) << len) | code64);
                free_next = free_reg - len;
            end
            else
            begin
                full_v = 1'b1;
                word64 = (64'(buf_reg) << free_reg) | (code64 >> rem);
                buf_next = WORD_BITS'(code64 & ((64'd1 << rem) - 64'd1));
                free_next = FB_W'(WORD_BITS) - rem;
            end
        end
        flush64 = 64'(buf_next) << free_next;
        // assemble result requests
        res0 = '0;
        res1 = '0;
        res0_v = 1'b0;
        res1_v = 1'b0;
        if (failed)
        begin
            res0_v = 1'b1;
            res0.last = 1'b1;
            res0.status = ST_NO_CODE;
            buf_next = '0;
            free_next = FB_W'(WORD_BITS);
        end
        else if (start)
        begin
            res0.packed_word = word64[OWORD_W-1:0];
            res0.word_valid = 1'b1;
            res0_v = full_v;
            if (is_eos && free_next != FB_W'(WORD_BITS))
            begin
                res1_v = 1'b1;
                res1.packed_word = flush64[OWORD_W-1:0];
                res1.word_valid = 1'b1;
                res1.last = 1'b1;
            end
            else
                res0.last = 1'b1;
            if (is_eos)
            begin
                buf_next = '0;
                free_next = FB_W'(WORD_BITS);
            end
        end
        // drop the buffered bits on a run overflow
        if (drop)
        begin
            buf_next = '0;
            free_next = FB_W'(WORD_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            free_reg <= FB_W'(WORD_BITS);
        end
        else
        begin
            buf_reg <= buf_next;
            free_reg <= free_next;
        end
    end
endmodule

// File: design/rlhp_checker.sv
// ----------------------------------------------------------------------------
// rlhp_checker
// Port-level checks of the packer core, bound to the top level.
// ----------------------------------------------------------------------------
module rlhp_checker
    import rlhp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);
    // no new request taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");

    // an error result carries no word and closes the item
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |->
        (out_data.last && !out_data.word_valid && out_data.packed_word == '0))
        else $error("bad error result");

    // an ok result always carries a word
    a_ok_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_OK) |-> out_data.word_valid)
        else $error("ok result without word");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
endmodule

bind run_length_huffman_bit_packer_core rlhp_checker u_rlhp_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/tb_run_length_huffman_bit_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_huffman_bit_packer_core
// Self-checking bench for the run-length packer. A queue of pending requests
// feeds a clocked driver. A clocked monitor predicts the packed words, error
// results and last flags of every accepted request. It compares each result
// request field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_run_length_huffman_bit_packer_core;
    import rlhp_pkg::*;

    localparam int NSLOTS     = TABLE_ENTRIES_DEF;
    localparam int WBITS      = WORD_BITS_DEF;
    localparam int RUN_MAX    = (1 << RUN_BITS_DEF) - 1;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 800;
    localparam int DRAIN_WAIT = 300;

    typedef struct {
        in_item_t req;
        bit       drain;
    } pending_t;

    logic clk;
    logic rst_n;

    rlhp_if #(.payload_t(in_item_t))  in_ch();
    rlhp_if #(.payload_t(out_item_t)) out_ch();

    run_length_huffman_bit_packer_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow of the codeword table and the stream state
    bit          slot_written [NSLOTS];
    logic [7:0]  slot_symbol  [NSLOTS];
    logic [15:0] slot_run     [NSLOTS];
    logic [31:0] slot_code    [NSLOTS];
    logic [5:0]  slot_len     [NSLOTS];
    logic [7:0]  run_symbol;
    int          run_len;
    bit          run_active;
    logic [31:0] bit_buffer;
    int          bits_free;
    bit          stream_halted;

    pending_t  pending_reqs[$];
    out_item_t expected_words[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_requests;
    int  holds_served;
    int  hold_left;
    int  idle_cycles;
    bit  in_taken;
    bit  failed;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_stream_state();
        run_symbol    = '0;
        run_len       = 0;
        run_active    = 1'b0;
        bit_buffer    = '0;
        bits_free     = WBITS;
        stream_halted = 1'b0;
    endfunction

    // pack the codeword of the open run; return 0 when no slot matches
    function automatic bit pack_run_code(ref out_item_t words[$]);
        int          hit;
        int          len;
        int          rem;
        logic [63:0] code;
        logic [63:0] word;
        out_item_t   res;
        hit = -1;
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (hit < 0 && slot_written[i] && slot_len[i] != 0 &&
                slot_symbol[i] == run_symbol && slot_run[i] == run_len)
                hit = i;
        end
        if (hit < 0)
            return 1'b0;
        len = slot_len[hit];
        if (len > 32)
            len = 32;
        if (len > WBITS)
            len = WBITS;
        code = {32'b0, slot_code[hit]} & ((64'h1 << len) - 1);
        if (len < bits_free)
        begin
            bit_buffer = 32'(({32'b0, bit_buffer} << len) | code);
            bits_free  = bits_free - len;
            return 1'b1;
        end
        rem  = len - bits_free;
        word = ({32'b0, bit_buffer} << bits_free) | (code >> rem);
        res.packed_word = word[31:0];
        res.word_valid  = 1'b1;
        res.last        = 1'b0;
        res.status      = ST_OK;
        words = {words, res};
        bit_buffer = 32'(code & ((64'h1 << rem) - 1));
        bits_free  = WBITS - rem;
        return 1'b1;
    endfunction

    function automatic out_item_t error_word(logic [1:0] cause);
        out_item_t res;
        res.packed_word = '0;
        res.word_valid  = 1'b0;
        res.last        = 1'b1;
        res.status      = cause;
        return res;
    endfunction

    // predict the result requests of one accepted request
    function automatic void predict_packer(in_item_t req);
        out_item_t   words[$];
        out_item_t   res;
        logic [63:0] flush;
        case (req.action)
            ACT_LOAD:
            begin
                slot_written[req.entry_slot] = 1'b1;
                slot_symbol[req.entry_slot]  = req.entry_symbol;
                slot_run[req.entry_slot]     = req.entry_run_length;
                slot_code[req.entry_slot]    = req.entry_code;
                slot_len[req.entry_slot]     = req.entry_code_length;
            end
            ACT_DATA:
            begin
                if (stream_halted)
                    ;
                else if (!run_active)
                begin
                    run_active = 1'b1;
                    run_symbol = req.data_byte;
                    run_len    = 1;
                end
                else if (req.data_byte == run_symbol)
                begin
                    if (run_len >= RUN_MAX)
                    begin
                        words = {words, error_word(ST_OVERFLOW)};
                        run_active    = 1'b0;
                        run_len       = 0;
                        bit_buffer    = '0;
                        bits_free     = WBITS;
                        stream_halted = 1'b1;
                    end
                    else
                        run_len++;
                end
                else if (!pack_run_code(words))
                begin
                    words = {words, error_word(ST_NO_CODE)};
                    run_active    = 1'b0;
                    run_len       = 0;
                    bit_buffer    = '0;
                    bits_free     = WBITS;
                    stream_halted = 1'b1;
                end
                else
                begin
                    run_symbol = req.data_byte;
                    run_len    = 1;
                end
            end
            ACT_EOS:
            begin
                if (stream_halted)
                    clear_stream_state();
                else if (run_active && !pack_run_code(words))
                begin
                    words = {words, error_word(ST_NO_CODE)};
                    clear_stream_state();
                end
                else
                begin
                    if (bits_free != WBITS)
                    begin
                        flush = {32'b0, bit_buffer} << bits_free;
                        res.packed_word = flush[31:0];
                        res.word_valid  = 1'b1;
                        res.last        = 1'b0;
                        res.status      = ST_OK;
                        words = {words, res};
                    end
                    clear_stream_state();
                end
            end
            default:
                ;
        endcase
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        foreach (words[i])
            expected_words = {expected_words, words[i]};
    endfunction

    // monitor: predict on input requests, check output requests
    always @(posedge clk)
    begin
        out_item_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_taken = 1'b1;
                predict_packer(in_ch.data);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%0t: unexpected result word=%h valid=%b last=%b status=%0d",
                             $time, out_ch.data.packed_word, out_ch.data.word_valid,
                             out_ch.data.last, out_ch.data.status);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_ch.data.packed_word !== want.packed_word)
                    begin
                        failed = 1'b1;
                        $display("%0t: packed_word expected %h actual %h",
                                 $time, want.packed_word, out_ch.data.packed_word);
                    end
                    if (out_ch.data.word_valid !== want.word_valid)
                    begin
                        failed = 1'b1;
                        $display("%0t: word_valid expected %b actual %b",
                                 $time, want.word_valid, out_ch.data.word_valid);
                    end
                    if (out_ch.data.last !== want.last)
                    begin
                        failed = 1'b1;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, out_ch.data.last);
                    end
                    if (out_ch.data.status !== want.status)
                    begin
                        failed = 1'b1;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_ch.data.status);
                    end
                end
            end
        end
    end

    // driver: hold the offered request until taken, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (in_ch.valid && !in_taken)
            ;
        else if (pending_reqs.size() > 0 &&
                 !(pending_reqs[0].drain && expected_words.size() > 0) &&
                 $urandom_range(99) >= send_idle_pct)
        begin
            in_ch.valid <= 1'b1;
            in_ch.data  <= pending_reqs[0].req;
            pending_reqs.pop_front();
        end
        else
            in_ch.valid <= 1'b0;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (holds_served < hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no request moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_req(logic [1:0] action, logic [7:0] slot, logic [7:0] symbol,
                             logic [15:0] run, logic [31:0] code, logic [5:0] len,
                             logic [7:0] data, bit drain);
        pending_t p;
        p.req.action            = action;
        p.req.entry_slot        = slot;
        p.req.entry_symbol      = symbol;
        p.req.entry_run_length  = run;
        p.req.entry_code        = code;
        p.req.entry_code_length = len;
        p.req.data_byte         = data;
        p.drain                 = drain;
        pending_reqs = {pending_reqs, p};
    endtask

    task automatic queue_load(logic [7:0] slot, logic [7:0] symbol, logic [15:0] run,
                              logic [31:0] code, logic [5:0] len);
        queue_req(ACT_LOAD, slot, symbol, run, code, len, 8'($urandom), 1'b0);
    endtask

    task automatic queue_byte(logic [7:0] data);
        queue_req(ACT_DATA, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                  6'($urandom), data, 1'b0);
    endtask

    task automatic queue_eos();
        queue_req(ACT_EOS, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                  6'($urandom), 8'($urandom), 1'b0);
    endtask

    // one stream: a table for a small alphabet, runs over it, then end of stream
    task automatic queue_stream(bit drain_first, output int count);
        logic [7:0] alphabet[4];
        int         nsym;
        int         base;
        int         k;
        int         nruns;
        int         pick;
        int         prev;
        int         len;
        logic [5:0] clen;
        count = 0;
        nsym  = $urandom_range(4, 2);
        base  = $urandom_range(255);
        k     = 0;
        for (int s = 0; s < nsym; s++)
            alphabet[s] = 8'($urandom);
        for (int s = 0; s < nsym; s++)
        begin
            for (int r = 1; r <= 4; r++)
            begin
                // leave a gap now and then so a lookup misses
                if ($urandom_range(19) != 0)
                begin
                    clen = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
                                                    : 6'($urandom_range(20, 1));
                    queue_load(8'(base + k), alphabet[s], 16'(r), $urandom, clen);
                    if (drain_first && count == 0)
                        pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
                    count++;
                end
                k++;
            end
        end
        nruns = $urandom_range(25, 8);
        prev  = -1;
        for (int i = 0; i < nruns; i++)
        begin
            pick = $urandom_range(nsym - 1);
            if (alphabet[pick] == alphabet[(pick + 1) % nsym] || pick == prev)
                pick = (pick + 1) % nsym;
            prev = pick;
            len  = $urandom_range(4, 1);
            for (int j = 0; j < len; j++)
            begin
                queue_byte(alphabet[pick]);
                count++;
            end
            // sprinkle noise: unknown action or a stray load
            if ($urandom_range(15) == 0)
            begin
                queue_req(2'd3, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                          6'($urandom), 8'($urandom), 1'b0);
                count++;
            end
            else if ($urandom_range(15) == 0)
            begin
                queue_load(8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                           6'($urandom));
                count++;
            end
        end
        queue_eos();
        count++;
    endtask

    task automatic wait_queue_drained();
        while (pending_reqs.size() > 0 || in_ch.valid)
            @(posedge clk);
    endtask

    initial
    begin
        int done_items;
        int n;
        failed        = 1'b0;
        idle_cycles   = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        in_taken      = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 59;
        for (int i = 0; i < NSLOTS; i++)
            slot_written[i] = 1'b0;
        clear_stream_state();
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty flush, unknown action, duplicate match, saturation
        queue_eos();
        queue_req(2'd3, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F, 8'hFF, 1'b0);
        queue_load(8'd0, 8'hAA, 16'd2, 32'h0000_0016, 6'd5);
        queue_load(8'd255, 8'hAA, 16'd2, 32'h0000_007F, 6'd7);
        queue_load(8'd1, 8'h00, 16'd1, 32'hFFFF_FFFF, 6'd40);
        queue_load(8'd3, 8'h55, 16'd1, 32'h0000_0001, 6'd0);
        queue_load(8'd4, 8'h55, 16'd1, 32'h0000_0003, 6'd2);
        queue_load(8'd5, 8'hFF, 16'hFFFF, 32'h8000_0001, 6'd63);
        queue_byte(8'hAA);
        queue_byte(8'hAA);
        queue_byte(8'h00);
        queue_byte(8'h55);
        queue_byte(8'h01);
        queue_eos();
        queue_byte(8'h00);
        queue_byte(8'hAA);
        queue_eos();
        // miss halts, bytes ignored and loads taken while halted
        queue_byte(8'h07);
        queue_byte(8'h08);
        queue_byte(8'h09);
        queue_load(8'd6, 8'h09, 16'd1, 32'h0000_0005, 6'd32);
        queue_eos();
        wait_queue_drained();

        // random streams in three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 12;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            done_items = 0;
            while (done_items < 135)
            begin
                // stall the receiver once while streams keep coming
                if (phase == 0 && done_items == 0)
                    hold_requests = hold_requests + 1;
                queue_stream(phase == 1 && done_items > 0, n);
                done_items += n;
            end
            wait_queue_drained();
        end

        while (pending_reqs.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
